FILE: src/sagp_pkg.sv
package sagp_pkg;

  localparam int GAIN_FRAC_BITS = 15;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
  localparam int DIST_W         = 24;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  typedef logic [GAIN_W-1:0] gain_t;
  typedef logic [DIST_W-1:0] dist_t;

  localparam gain_t GAIN_ONE   = gain_t'(1) << GAIN_FRAC_BITS;
  localparam gain_t GAIN_HALF  = gain_t'(1) << (GAIN_FRAC_BITS - 1);
  localparam dist_t DIST_FLOOR = dist_t'(26);
  localparam dist_t MIN_RESET  = dist_t'(256);
  localparam dist_t MAX_RESET  = dist_t'(25600);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_VOLUME   = 3'd0,
    REG_MIN_DISTANCE  = 3'd1,
    REG_MAX_DISTANCE  = 3'd2,
    REG_SOURCE_X      = 3'd3,
    REG_SOURCE_Y      = 3'd4,
    REG_SOURCE_Z      = 3'd5,
    REG_SOUND_PLAYING = 3'd6
  } cfg_reg_t;

endpackage

FILE: src/spatial_audio_gain_pan.sv
// Distance attenuation and stereo pan for one sound source.
// Input channel (in_valid/in_stall): one listener position per request, signed
// Q16.8 coordinates. Result channel (out_valid/out_stall): one request per
// input with left, right and mix gains (Q1.15), the listener distance (Q17.8)
// and gains_valid, which follows sound_playing.
// Configuration channel (cfg_valid/cfg_ready): register index and data;
// cfg_ready is always high. Write only while no request is in flight.
// A request passes through registers for difference, squares and sum, the
// square-root stages for the root bits, a divider set-up register, the
// quotient-bit stages of the three restoring dividers, and the volume
// multiply, pan multiply and output registers.
// Throughput is one request per cycle while no result waits under out_stall.
// Reset clears every valid bit and loads the register defaults: full volume,
// minimum distance 1.0, maximum 100.0, source at the origin, not playing.
// While a result waits under out_stall the whole pipeline holds and in_stall
// is raised in the same cycle; nothing is dropped or repeated.
module spatial_audio_gain_pan
  import sagp_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] in_listener_x,
  input  logic [COORD_WIDTH-1:0] in_listener_y,
  input  logic [COORD_WIDTH-1:0] in_listener_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [GAIN_W-1:0]      out_left_gain,
  output logic [GAIN_W-1:0]      out_right_gain,
  output logic [GAIN_W-1:0]      out_mix_gain,
  output logic [COORD_WIDTH:0]   out_listener_distance,
  output logic                   out_gains_valid,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int NB = CW + 1;          // root bits
  localparam int RW = 2 * NB;          // radicand bits
  localparam int RMW = NB + 2;         // root remainder bits
  localparam int DW = ((NB + 1) > DIST_W ? (NB + 1) : DIST_W) + 1;
  localparam int QB = GAIN_FRAC_BITS + 1;

  // configuration registers
  gain_t           base_r;
  dist_t           min_r;
  dist_t           max_r;
  logic [CW-1:0]   src_x_r, src_y_r, src_z_r;
  logic            play_r;

  logic            adv;
  dist_t           cfg_d24;
  dist_t           cfg_min;

  assign cfg_ready = 1'b1;
  assign cfg_d24   = cfg_data[DIST_W-1:0];
  assign cfg_min   = (cfg_d24 > DIST_FLOOR) ? cfg_d24 : DIST_FLOOR;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= GAIN_ONE;
      min_r   <= MIN_RESET;
      max_r   <= MAX_RESET;
      src_x_r <= '0;
      src_y_r <= '0;
      src_z_r <= '0;
      play_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASE_VOLUME: begin
          base_r <= (cfg_data[GAIN_W-1:0] > GAIN_ONE) ? GAIN_ONE : cfg_data[GAIN_W-1:0];
        end
        REG_MIN_DISTANCE: begin
          min_r <= cfg_min;
          if (max_r < cfg_min) max_r <= cfg_min;
        end
        REG_MAX_DISTANCE: begin
          max_r <= (cfg_d24 > min_r) ? cfg_d24 : min_r;
        end
        REG_SOURCE_X:      src_x_r <= cfg_data[CW-1:0];
        REG_SOURCE_Y:      src_y_r <= cfg_data[CW-1:0];
        REG_SOURCE_Z:      src_z_r <= cfg_data[CW-1:0];
        REG_SOUND_PLAYING: play_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // global advance: hold everything while the result waits
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1: differences and magnitudes
  logic [CW:0]   dx, dy, dz;
  logic [CW:0]   ndx, ndy, ndz;
  logic          p1_vld_r;
  logic [CW-1:0] p1_ax_r, p1_ay_r, p1_az_r;
  logic          p1_neg_r;

  always_comb begin
    dx  = {src_x_r[CW-1], src_x_r} - {in_listener_x[CW-1], in_listener_x};
    dy  = {src_y_r[CW-1], src_y_r} - {in_listener_y[CW-1], in_listener_y};
    dz  = {src_z_r[CW-1], src_z_r} - {in_listener_z[CW-1], in_listener_z};
    ndx = ~dx + 1'b1;
    ndy = ~dy + 1'b1;
    ndz = ~dz + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_ax_r  <= dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
      p1_ay_r  <= dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
      p1_az_r  <= dz[CW] ? ndz[CW-1:0] : dz[CW-1:0];
      p1_neg_r <= dx[CW];
    end
  end

  // stage 2: squares
  logic            p2_vld_r;
  logic [2*CW-1:0] p2_sx_r, p2_sy_r, p2_sz_r;
  logic [CW-1:0]   p2_ax_r;
  logic            p2_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (adv) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_sx_r  <= {{CW{1'b0}}, p1_ax_r} * {{CW{1'b0}}, p1_ax_r};
      p2_sy_r  <= {{CW{1'b0}}, p1_ay_r} * {{CW{1'b0}}, p1_ay_r};
      p2_sz_r  <= {{CW{1'b0}}, p1_az_r} * {{CW{1'b0}}, p1_az_r};
      p2_ax_r  <= p1_ax_r;
      p2_neg_r <= p1_neg_r;
    end
  end

  // square root: entry 0 holds the sum, one root bit per stage after it
  logic            sq_vld_r  [0:NB];
  logic [RW-1:0]   sq_v_r    [0:NB];
  logic [RMW-1:0]  sq_rem_r  [0:NB];
  logic [NB-1:0]   sq_root_r [0:NB];
  logic [CW-1:0]   sq_ax_r   [0:NB];
  logic            sq_neg_r  [0:NB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_r[0] <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_v_r[0]    <= {2'b00, p2_sx_r} + {2'b00, p2_sy_r} + {2'b00, p2_sz_r};
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_ax_r[0]   <= p2_ax_r;
      sq_neg_r[0]  <= p2_neg_r;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_sqrt
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    logic           ge;

    always_comb begin
      rem_sh = {sq_rem_r[k][RMW-3:0], sq_v_r[k][RW-1:RW-2]};
      trial  = {sq_root_r[k], 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_v_r[k+1]    <= {sq_v_r[k][RW-3:0], 2'b00};
        sq_rem_r[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
        sq_root_r[k+1] <= {sq_root_r[k][NB-2:0], ge};
        sq_ax_r[k+1]   <= sq_ax_r[k];
        sq_neg_r[k+1]  <= sq_neg_r[k];
      end
    end
  end

  // divider set-up, then one quotient bit per stage for three dividers
  logic            dv_vld_r   [0:QB];
  logic [DW-1:0]   dv_arem_r  [0:QB];
  logic [DW-1:0]   dv_lrem_r  [0:QB];
  logic [DW-1:0]   dv_rrem_r  [0:QB];
  logic [DW-1:0]   dv_aden_r  [0:QB];
  logic [DW-1:0]   dv_pden_r  [0:QB];
  logic [QB-1:0]   dv_aq_r    [0:QB];
  logic [QB-1:0]   dv_lq_r    [0:QB];
  logic [QB-1:0]   dv_rq_r    [0:QB];
  logic [NB-1:0]   dv_d_r     [0:QB];
  logic            dv_one_r   [0:QB];
  logic            dv_zero_r  [0:QB];
  logic            dv_ctr_r   [0:QB];

  logic [NB-1:0]   d_root;
  logic [DW-1:0]   d_ext, ax_ext, min_ext, max_ext;
  logic [DW-1:0]   near_n, far_n;

  always_comb begin
    d_root  = sq_root_r[NB];
    d_ext   = DW'(d_root);
    ax_ext  = DW'(sq_ax_r[NB]);
    min_ext = DW'(min_r);
    max_ext = DW'(max_r);
    near_n  = d_ext - ax_ext;
    far_n   = d_ext + ax_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_r[0] <= sq_vld_r[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_arem_r[0] <= d_ext - min_ext;
      dv_aden_r[0] <= max_ext - min_ext;
      dv_lrem_r[0] <= sq_neg_r[NB] ? far_n : near_n;
      dv_rrem_r[0] <= sq_neg_r[NB] ? near_n : far_n;
      dv_pden_r[0] <= {d_ext[DW-2:0], 1'b0};
      dv_aq_r[0]   <= '0;
      dv_lq_r[0]   <= '0;
      dv_rq_r[0]   <= '0;
      dv_d_r[0]    <= d_root;
      dv_one_r[0]  <= (d_ext <= min_ext);
      dv_zero_r[0] <= (d_ext >= max_ext);
      dv_ctr_r[0]  <= (d_root == '0);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [DW-1:0] a_in, l_in, r_in;
    logic          a_ge, l_ge, r_ge;

    always_comb begin
      if (k == 0) begin
        a_in = dv_arem_r[k];
        l_in = dv_lrem_r[k];
        r_in = dv_rrem_r[k];
      end else begin
        a_in = {dv_arem_r[k][DW-2:0], 1'b0};
        l_in = {dv_lrem_r[k][DW-2:0], 1'b0};
        r_in = {dv_rrem_r[k][DW-2:0], 1'b0};
      end
      a_ge = (a_in >= dv_aden_r[k]);
      l_ge = (l_in >= dv_pden_r[k]);
      r_ge = (r_in >= dv_pden_r[k]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_arem_r[k+1] <= a_ge ? (a_in - dv_aden_r[k]) : a_in;
        dv_lrem_r[k+1] <= l_ge ? (l_in - dv_pden_r[k]) : l_in;
        dv_rrem_r[k+1] <= r_ge ? (r_in - dv_pden_r[k]) : r_in;
        dv_aq_r[k+1]   <= {dv_aq_r[k][QB-2:0], a_ge};
        dv_lq_r[k+1]   <= {dv_lq_r[k][QB-2:0], l_ge};
        dv_rq_r[k+1]   <= {dv_rq_r[k][QB-2:0], r_ge};
        dv_aden_r[k+1] <= dv_aden_r[k];
        dv_pden_r[k+1] <= dv_pden_r[k];
        dv_d_r[k+1]    <= dv_d_r[k];
        dv_one_r[k+1]  <= dv_one_r[k];
        dv_zero_r[k+1] <= dv_zero_r[k];
        dv_ctr_r[k+1]  <= dv_ctr_r[k];
      end
    end
  end

  // volume multiply
  gain_t             att;
  logic [2*GAIN_W-1:0] vol_p;
  logic              m1_vld_r;
  gain_t             m1_vol_r, m1_l_r, m1_r_r;
  logic [NB-1:0]     m1_d_r;

  always_comb begin
    if (dv_one_r[QB]) begin
      att = GAIN_ONE;
    end else if (dv_zero_r[QB]) begin
      att = '0;
    end else begin
      att = GAIN_ONE - gain_t'(dv_aq_r[QB]);
    end
    vol_p = {{GAIN_W{1'b0}}, base_r} * {{GAIN_W{1'b0}}, att};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (adv) begin
      m1_vld_r <= dv_vld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_vol_r <= vol_p[GAIN_FRAC_BITS +: GAIN_W];
      m1_l_r   <= dv_ctr_r[QB] ? GAIN_HALF : gain_t'(dv_lq_r[QB]);
      m1_r_r   <= dv_ctr_r[QB] ? GAIN_HALF : gain_t'(dv_rq_r[QB]);
      m1_d_r   <= dv_d_r[QB];
    end
  end

  // pan multiply, gated by playing
  logic [2*GAIN_W-1:0] lg_p, rg_p;
  logic                m2_vld_r;
  gain_t               m2_lg_r, m2_rg_r;
  logic [NB-1:0]       m2_d_r;

  always_comb begin
    lg_p = {{GAIN_W{1'b0}}, m1_l_r} * {{GAIN_W{1'b0}}, m1_vol_r};
    rg_p = {{GAIN_W{1'b0}}, m1_r_r} * {{GAIN_W{1'b0}}, m1_vol_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (adv) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_lg_r <= play_r ? lg_p[GAIN_FRAC_BITS +: GAIN_W] : '0;
      m2_rg_r <= play_r ? rg_p[GAIN_FRAC_BITS +: GAIN_W] : '0;
      m2_d_r  <= m1_d_r;
    end
  end

  // output register
  logic          out_valid_r;
  gain_t         out_lg_r, out_rg_r, out_mix_r;
  logic [NB-1:0] out_d_r;
  logic          out_play_r;
  logic [GAIN_W:0] mix_sum;

  assign mix_sum = {1'b0, m2_lg_r} + {1'b0, m2_rg_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_lg_r   <= m2_lg_r;
      out_rg_r   <= m2_rg_r;
      out_mix_r  <= mix_sum[GAIN_W:1];
      out_d_r    <= m2_d_r;
      out_play_r <= play_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_left_gain         = out_lg_r;
  assign out_right_gain        = out_rg_r;
  assign out_mix_gain          = out_mix_r;
  assign out_listener_distance = out_d_r;
  assign out_gains_valid       = out_play_r;

endmodule

FILE: src/sagp_checker.sv
module sagp_checker
  import sagp_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [GAIN_W-1:0]      out_left_gain,
  input logic [GAIN_W-1:0]      out_right_gain,
  input logic [GAIN_W-1:0]      out_mix_gain,
  input logic [COORD_WIDTH:0]   out_listener_distance,
  input logic                   out_gains_valid
);

  logic [GAIN_W:0] sum_lr;
  assign sum_lr = {1'b0, out_left_gain} + {1'b0, out_right_gain};

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_gain)
      && $stable(out_right_gain) && $stable(out_listener_distance))
    else $error("stalled result changed");

  // input backs up only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow output stall");

  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_gains_valid |-> out_left_gain == '0
      && out_right_gain == '0 && out_mix_gain == '0)
    else $error("gains not zero while not playing");

  a_mix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mix_gain == sum_lr[GAIN_W:1])
    else $error("mix gain is not the mean");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left_gain <= GAIN_ONE && out_right_gain <= GAIN_ONE)
    else $error("gain above one");

endmodule

bind spatial_audio_gain_pan sagp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sagp_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_left_gain         (out_left_gain),
  .out_right_gain        (out_right_gain),
  .out_mix_gain          (out_mix_gain),
  .out_listener_distance (out_listener_distance),
  .out_gains_valid       (out_gains_valid)
);

FILE: dv/tb_spatial_audio_gain_pan.sv
module tb_spatial_audio_gain_pan;
  import sagp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 24;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint unsigned UNITY = 64'd1 << GAIN_FRAC_BITS;
  localparam int TAIL_CYCLES = 80;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [GAIN_W-1:0] left;
    logic [GAIN_W-1:0] right;
    logic [GAIN_W-1:0] mix;
    logic [CW:0]       distance;
    logic              playing;
  } gain_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [CW-1:0] in_listener_x;
  logic [CW-1:0] in_listener_y;
  logic [CW-1:0] in_listener_z;
  logic out_valid;
  logic out_stall;
  logic [GAIN_W-1:0] out_left_gain;
  logic [GAIN_W-1:0] out_right_gain;
  logic [GAIN_W-1:0] out_mix_gain;
  logic [CW:0] out_listener_distance;
  logic out_gains_valid;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  spatial_audio_gain_pan #(.COORD_WIDTH(CW)) DUT (.*);

  // Shadow register file
  longint unsigned volume_m;
  longint unsigned min_dist_m;
  longint unsigned max_dist_m;
  longint src_x_m;
  longint src_y_m;
  longint src_z_m;
  logic playing_m;

  gain_result_t gain_expect_q[$];
  int errors = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit long_hold_req = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic gain_result_t predict_gains(logic [CW-1:0] lx, logic [CW-1:0] ly,
                                                 logic [CW-1:0] lz);
    gain_result_t res;
    longint dx, dy, dz;
    longint unsigned ax, ay, az, d, att, vol, l, r, ln, rn, lg, rg, mx;
    dx = src_x_m - longint'($signed(lx));
    dy = src_y_m - longint'($signed(ly));
    dz = src_z_m - longint'($signed(lz));
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    d = int_sqrt(ax * ax + ay * ay + az * az);
    if (d <= min_dist_m) att = UNITY;
    else if (d >= max_dist_m) att = 0;
    else att = UNITY - ((d - min_dist_m) * UNITY) / (max_dist_m - min_dist_m);
    vol = (volume_m * att) >> GAIN_FRAC_BITS;
    if (vol > UNITY) vol = UNITY;
    if (d == 0) begin
      l = UNITY / 2;
      r = UNITY / 2;
    end else begin
      if (dx < 0) begin
        ln = d + ax;
        rn = d > ax ? d - ax : 0;
      end else begin
        ln = d > ax ? d - ax : 0;
        rn = d + ax;
      end
      l = (ln * UNITY) / (2 * d);
      r = (rn * UNITY) / (2 * d);
      if (l > UNITY) l = UNITY;
      if (r > UNITY) r = UNITY;
    end
    lg = 0;
    rg = 0;
    if (playing_m) begin
      lg = (l * vol) >> GAIN_FRAC_BITS;
      rg = (r * vol) >> GAIN_FRAC_BITS;
    end
    mx = (lg + rg) >> 1;
    res.left = lg[GAIN_W-1:0];
    res.right = rg[GAIN_W-1:0];
    res.mix = mx[GAIN_W-1:0];
    res.distance = d[CW:0];
    res.playing = playing_m;
    return res;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    longint unsigned v;
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BASE_VOLUME: begin
        v = data[15:0];
        volume_m = v > UNITY ? UNITY : v;
      end
      REG_MIN_DISTANCE: begin
        v = data[23:0];
        min_dist_m = v > DIST_FLOOR ? v : DIST_FLOOR;
        if (max_dist_m < min_dist_m) max_dist_m = min_dist_m;
      end
      REG_MAX_DISTANCE: begin
        v = data[23:0];
        max_dist_m = v > min_dist_m ? v : min_dist_m;
      end
      REG_SOURCE_X: src_x_m = longint'($signed(data[CW-1:0]));
      REG_SOURCE_Y: src_y_m = longint'($signed(data[CW-1:0]));
      REG_SOURCE_Z: src_z_m = longint'($signed(data[CW-1:0]));
      REG_SOUND_PLAYING: playing_m = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Send one listener position; bursts separated by random gaps
  task automatic send_pos(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1;
    in_listener_x = x;
    in_listener_y = y;
    in_listener_z = z;
    do @(posedge clk); while (in_stall);
    gain_expect_q.push_back(predict_gains(x, y, z));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid = 0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    while (gain_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] near_source(longint src);
    longint span, off;
    span = longint'(max_dist_m) + longint'(max_dist_m / 4) + 1;
    if (span > (64'sd1 << 22)) span = 64'sd1 << 22;
    off = longint'($urandom_range(0, 32'(2 * span))) - span;
    return CW'(src + off);
  endfunction

  task automatic test_reset_defaults();
    send_pos('0, '0, '0);
    send_pos(24'h000100, 24'h000000, 24'h000000);
    send_pos(24'h7FFFFF, 24'h800000, 24'h123456);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_directed();
    write_reg(REG_SOUND_PLAYING, 32'h1);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_pos('0, '0, '0);
    send_pos(24'h000100, '0, '0);
    send_pos(24'hFFFF00, '0, '0);
    send_pos(24'h006400, '0, '0);
    send_pos('0, 24'h003200, '0);
    send_pos(24'h001000, 24'h001000, 24'h001000);
    send_pos(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_pos(24'h800000, 24'h800000, 24'h800000);
    send_pos(24'h000001, '0, '0);
    stop_sending();
    wait_drained();
    write_reg(REG_BASE_VOLUME, 32'hFFFF_FFFF);
    write_reg(REG_MIN_DISTANCE, 32'h0);
    write_reg(REG_MAX_DISTANCE, 32'h5);
    write_reg(REG_SOURCE_X, 32'h0080_0000);
    write_reg(REG_SOURCE_Y, 32'h007F_FFFF);
    write_reg(REG_SOURCE_Z, 32'hFF80_0000);
    send_pos(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send_pos(24'h800000, 24'h7FFFFF, 24'h800000);
    send_pos(24'h800000, 24'h7FFFFF, 24'h800010);
    send_pos(24'h800019, 24'h7FFFFF, 24'h800000);
    stop_sending();
    wait_drained();
    write_reg(REG_BASE_VOLUME, 32'h4000);
    write_reg(REG_MAX_DISTANCE, 32'h00FF_FFFF);
    write_reg(REG_MIN_DISTANCE, 32'h0100_0010);
    write_reg(REG_SOURCE_X, 32'h0);
    write_reg(REG_SOURCE_Y, 32'h0);
    write_reg(REG_SOURCE_Z, 32'h0);
    send_pos(24'h000010, '0, '0);
    send_pos(24'h000011, '0, '0);
    send_pos(24'hFFFFEF, '0, '0);
    stop_sending();
    wait_drained();
    write_reg(REG_MIN_DISTANCE, 32'h0000_0100);
    write_reg(REG_MAX_DISTANCE, 32'h0000_0300);
    write_reg(REG_BASE_VOLUME, 32'h0);
    send_pos(24'h000200, '0, '0);
    stop_sending();
    wait_drained();
    write_reg(REG_BASE_VOLUME, 32'h8000);
    send_pos(24'h000200, '0, '0);
    send_pos(24'h000300, '0, '0);
    send_pos(24'hFFFE80, 24'h000100, '0);
    stop_sending();
    wait_drained();
  endtask

  task automatic randomise_registers();
    int pick;
    pick = $urandom_range(0, 4);
    write_reg(REG_BASE_VOLUME, pick == 0 ? 32'h0 : pick == 1 ? 32'h8000 :
              pick == 2 ? $urandom() : $urandom_range(0, 32768));
    pick = $urandom_range(0, 5);
    write_reg(REG_MIN_DISTANCE, pick == 0 ? 32'd26 : pick == 1 ? 32'h0 :
              pick == 2 ? 32'h00FF_FFFF : pick == 3 ? $urandom() :
              $urandom_range(0, 8000));
    pick = $urandom_range(0, 4);
    write_reg(REG_MAX_DISTANCE, pick == 0 ? 32'h00FF_FFFF : pick == 1 ? $urandom() :
              pick == 2 ? 32'(min_dist_m) : 32'(min_dist_m) + $urandom_range(1, 40000));
    if ($urandom_range(0, 2) == 0) begin
      write_reg(REG_SOURCE_X, $urandom());
      write_reg(REG_SOURCE_Y, $urandom());
      write_reg(REG_SOURCE_Z, $urandom());
    end else begin
      write_reg(REG_SOURCE_X, 32'($signed($urandom_range(0, 20000)) - 10000));
      write_reg(REG_SOURCE_Y, 32'($signed($urandom_range(0, 20000)) - 10000));
      write_reg(REG_SOURCE_Z, 32'($signed($urandom_range(0, 20000)) - 10000));
    end
    write_reg(REG_SOUND_PLAYING, $urandom_range(0, 4) == 0 ? 32'hFFFF_FFFE : $urandom());
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom());
  endtask

  task automatic send_random_pos();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 6)
      send_pos(near_source(src_x_m), near_source(src_y_m), near_source(src_z_m));
    else if (mode < 8)
      send_pos(CW'($urandom()), CW'($urandom()), CW'($urandom()));
    else if (mode == 8)
      send_pos(near_source(src_x_m), CW'(src_y_m), CW'(src_z_m));
    else
      send_pos(CW'(src_x_m), CW'(src_y_m), CW'(src_z_m));
  endtask

  task automatic test_random_settings();
    repeat (15) begin
      randomise_registers();
      repeat (90) send_random_pos();
      stop_sending();
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_SOUND_PLAYING, 32'h1);
    long_hold_req = 1;
    repeat (170) send_random_pos();
    stop_sending();
    wait_drained();
  endtask

  // Receiver stall pattern, with a long hold on request
  initial begin
    int mode;
    int len;
    out_stall = 0;
    forever begin
      if (long_hold_req) begin
        @(negedge clk);
        out_stall = 1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        long_hold_req = 0;
      end
      mode = $urandom_range(0, 2);
      len = $urandom_range(1, 40);
      repeat (len) begin
        @(negedge clk);
        out_stall = mode == 0 ? 1'b0 : mode == 1 ? ($urandom_range(0, 3) == 0)
                                                 : 1'($urandom_range(0, 1));
      end
    end
  end

  always @(posedge clk) begin
    gain_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (gain_expect_q.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected result at %0t", $realtime);
        mismatches++;
      end else begin
        exp_res = gain_expect_q.pop_front();
        if (out_left_gain !== exp_res.left || out_right_gain !== exp_res.right ||
            out_mix_gain !== exp_res.mix || out_listener_distance !== exp_res.distance ||
            out_gains_valid !== exp_res.playing) begin
          errors++;
          if (mismatches < 10)
            $display({"mismatch: exp l=%0d r=%0d m=%0d d=%0d v=%0d",
                      " got l=%0d r=%0d m=%0d d=%0d v=%0d"},
                     exp_res.left, exp_res.right, exp_res.mix, exp_res.distance,
                     exp_res.playing,
                     out_left_gain, out_right_gain, out_mix_gain, out_listener_distance,
                     out_gains_valid);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: cycles without any transfer on the input, result or configuration channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_listener_x = '0;
    in_listener_y = '0;
    in_listener_z = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    volume_m = UNITY;
    min_dist_m = MIN_RESET;
    max_dist_m = MAX_RESET;
    src_x_m = 0;
    src_y_m = 0;
    src_z_m = 0;
    playing_m = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_reset_defaults();
    test_directed();
    test_backpressure();
    test_random_settings();
    if (gain_expect_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: spatial_audio_gain_pan.f
src/sagp_pkg.sv
src/spatial_audio_gain_pan.sv
src/sagp_checker.sv
dv/tb_spatial_audio_gain_pan.sv
